// File: rtl/core/ir_ac_frame_pulse_encoder_defines.svh
// Assertion macros shared by the IR frame encoder RTL.
// Depends on nothing; users supply clk_i and rst_ni in scope.
`ifndef IR_AC_FRAME_PULSE_ENCODER_DEFINES_SVH
`define IR_AC_FRAME_PULSE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IRAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IRAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/irac_pkg.sv
// Package for the IR frame encoder: types, register indexes and constants.
// Used by every module of the block; depends on nothing.
package irac_pkg;

  localparam int unsigned DUR_W      = 16;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [POS_W-1:0] POS_LAST  = 5'd20;
  localparam logic [POS_W-1:0] POS_SEC1  = 5'd5;
  localparam logic [POS_W-1:0] POS_SEC2  = 5'd13;
  localparam logic [POS_W-1:0] POS_CSUM1 = 5'd13;
  localparam logic [POS_W-1:0] POS_CSUM2 = 5'd20;
  localparam logic [POS_W-1:0] POS_XOR_LO1 = 5'd2;
  localparam logic [POS_W-1:0] POS_XOR_HI1 = 5'd12;
  localparam logic [POS_W-1:0] POS_XOR_LO2 = 5'd14;
  localparam logic [POS_W-1:0] POS_XOR_HI2 = 5'd19;

  localparam logic [DUR_W-1:0] RST_HDR_MARK  = 16'd9000;
  localparam logic [DUR_W-1:0] RST_HDR_SPACE = 16'd4600;
  localparam logic [DUR_W-1:0] RST_BIT_MARK  = 16'd560;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE = 16'd1680;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 16'd600;
  localparam logic [DUR_W-1:0] RST_FOOTER    = 16'd8000;
  localparam logic [DUR_W-1:0] RST_GAP       = 16'd20000;

  // Sequencer steps: header, eight bits, trailer.
  localparam logic [3:0] STEP_HDR      = 4'd0;
  localparam logic [3:0] STEP_BIT0     = 4'd1;
  localparam logic [3:0] STEP_BIT7     = 4'd8;
  localparam logic [3:0] STEP_TRAILER  = 4'd9;

  typedef enum logic [2:0] {
    REG_HDR_MARK   = 3'd0,
    REG_HDR_SPACE  = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ONE_SPACE  = 3'd3,
    REG_ZERO_SPACE = 3'd4,
    REG_FOOTER     = 3'd5,
    REG_GAP        = 3'd6,
    REG_CSUM       = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    TRL_NONE   = 2'd0,
    TRL_FOOTER = 2'd1,
    TRL_GAP    = 2'd2
  } trailer_e;

  typedef struct packed {
    logic [DUR_W-1:0] hdr_mark;
    logic [DUR_W-1:0] hdr_space;
    logic [DUR_W-1:0] bit_mark;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] zero_space;
    logic [DUR_W-1:0] footer;
    logic [DUR_W-1:0] gap;
    logic             insert_csum;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       header;
    trailer_e   trailer;
  } desc_t;

endpackage

// File: rtl/core/irac_front.sv
// Front end of the IR frame encoder: tracks byte position and running XOR,
// substitutes checksums and classifies each byte. Depends on irac_pkg.
module irac_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_data_i,
  input  logic                in_start_i,
  input  logic                insert_csum_i,
  output logic                push_o,
  output irac_pkg::desc_t     push_desc_o,
  input  logic                push_ready_i
);

  logic [irac_pkg::POS_W-1:0] pos_q, pos_d, pos;
  logic [7:0]                 xor_q, xor_d, xor_cur, byte_eff;
  logic                       accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  always_comb begin
    pos     = in_start_i ? '0 : pos_q;
    xor_cur = in_start_i ? '0 : xor_q;
    byte_eff = in_data_i;
    if (insert_csum_i && (pos == irac_pkg::POS_CSUM1 || pos == irac_pkg::POS_CSUM2)) begin
      byte_eff = xor_cur;
    end

    push_desc_o.data   = byte_eff;
    push_desc_o.header = (pos == '0);
    if (pos == irac_pkg::POS_SEC1 || pos == irac_pkg::POS_SEC2) begin
      push_desc_o.trailer = irac_pkg::TRL_FOOTER;
    end else if (pos == irac_pkg::POS_LAST) begin
      push_desc_o.trailer = irac_pkg::TRL_GAP;
    end else begin
      push_desc_o.trailer = irac_pkg::TRL_NONE;
    end

    xor_d = xor_q;
    pos_d = pos_q;
    if (accept) begin
      if ((pos >= irac_pkg::POS_XOR_LO1 && pos <= irac_pkg::POS_XOR_HI1) ||
          (pos >= irac_pkg::POS_XOR_LO2 && pos <= irac_pkg::POS_XOR_HI2)) begin
        xor_d = xor_cur ^ byte_eff;
      end else if (pos == irac_pkg::POS_CSUM1 || pos >= irac_pkg::POS_LAST) begin
        xor_d = '0;
      end else begin
        xor_d = xor_cur;
      end
      pos_d = (pos >= irac_pkg::POS_LAST) ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      xor_q <= '0;
    end else begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

endmodule

// File: rtl/core/irac_fifo.sv
// Small descriptor queue between front and back of the IR frame encoder.
// Depends on irac_pkg; Depth must be a power of two, at least two.
module irac_fifo #(
  parameter int unsigned Depth = irac_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  irac_pkg::desc_t push_desc_i,
  output logic            push_ready_o,
  input  logic            pop_i,
  output irac_pkg::desc_t pop_desc_o,
  output logic            pop_valid_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  irac_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/core/irac_back.sv
// Back end of the IR frame encoder: steps through a byte's pairs, one a
// cycle unless stalled, into the output register. Depends on irac_pkg.
module irac_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  irac_pkg::desc_t             head_desc_i,
  output logic                        pop_o,
  input  irac_pkg::cfg_t              cfg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [irac_pkg::DUR_W-1:0]  out_mark_o,
  output logic [irac_pkg::DUR_W-1:0]  out_space_o,
  output logic                        out_run_last_o,
  output logic                        out_frame_last_o
);

  logic [3:0]                 step_q, step_d, cur_step;
  logic [2:0]                 bit_idx;
  logic                       fire, last;
  logic                       valid_q, valid_d;
  logic [irac_pkg::DUR_W-1:0] mark_q, mark_d, space_q, space_d;
  logic                       run_last_q, run_last_d, frame_last_q, frame_last_d;

  assign fire = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o = fire && last;

  always_comb begin
    cur_step = step_q;
    if (step_q == irac_pkg::STEP_HDR && !head_desc_i.header) begin
      cur_step = irac_pkg::STEP_BIT0;
    end
    bit_idx = 3'(cur_step - irac_pkg::STEP_BIT0);
    last = (cur_step == irac_pkg::STEP_TRAILER) ||
           (cur_step == irac_pkg::STEP_BIT7 && head_desc_i.trailer == irac_pkg::TRL_NONE);

    step_d = step_q;
    if (fire) begin
      step_d = last ? irac_pkg::STEP_HDR : cur_step + 4'd1;
    end
  end

  always_comb begin
    valid_d      = valid_q;
    mark_d       = mark_q;
    space_d      = space_q;
    run_last_d   = run_last_q;
    frame_last_d = frame_last_q;
    if (fire) begin
      valid_d      = 1'b1;
      run_last_d   = last;
      frame_last_d = 1'b0;
      mark_d       = cfg_i.bit_mark;
      if (cur_step == irac_pkg::STEP_HDR) begin
        mark_d  = cfg_i.hdr_mark;
        space_d = cfg_i.hdr_space;
      end else if (cur_step == irac_pkg::STEP_TRAILER) begin
        if (head_desc_i.trailer == irac_pkg::TRL_GAP) begin
          space_d      = cfg_i.gap;
          frame_last_d = 1'b1;
        end else begin
          space_d = cfg_i.footer;
        end
      end else begin
        space_d = head_desc_i.data[bit_idx] ? cfg_i.one_space : cfg_i.zero_space;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_q       <= mark_d;
    space_q      <= space_d;
    run_last_q   <= run_last_d;
    frame_last_q <= frame_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= irac_pkg::STEP_HDR;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_mark_o       = mark_q;
  assign out_space_o      = space_q;
  assign out_run_last_o   = run_last_q;
  assign out_frame_last_o = frame_last_q;

endmodule

// File: rtl/core/ir_ac_frame_pulse_encoder.sv
// Top level of the IR frame encoder: configuration registers, front end,
// descriptor queue and pair sequencer. Depends on irac_pkg and the defines.
//
// The slave stream takes one frame byte per transfer; tuser marks byte 0 of
// a new frame. The master stream gives one mark/space pair per transfer;
// tlast marks the last pair of a byte and tuser the frame gap pair.
// Bytes 0, 5, 13 and 20 of a frame give nine pairs, all others eight.
// The sequencer emits one pair per cycle unless stalled, and goes straight on
// to the next queued byte. A byte sent to an empty queue is written into the
// queue first and only then gives its first pair to the output register.
// The queue holds FifoDepth classified bytes, so the slave side keeps
// accepting while the sequencer works or the receiver stalls; once it is
// full, s_axis_tready_o drops until the sequencer finishes a byte.
// A receiver stall holds the output register and freezes the sequencer.
// Reset clears position, running XOR, queue and output valid, and loads the
// default durations. Configuration writes are accepted in every cycle and
// should be made while the block is idle.
`include "ir_ac_frame_pulse_encoder_defines.svh"
module ir_ac_frame_pulse_encoder #(
  parameter int unsigned FifoDepth = irac_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] mark_us, [31:16] space_us
  output logic        m_axis_tlast_o,   // run_last
  output logic        m_axis_tuser_o,   // [0] frame_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  irac_pkg::cfg_t  cfg_q, cfg_d;
  irac_pkg::desc_t push_desc, head_desc;
  logic            push, push_ready, head_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (irac_pkg::reg_idx_e'(cfg_index_i))
        irac_pkg::REG_HDR_MARK:   cfg_d.hdr_mark    = cfg_data_i;
        irac_pkg::REG_HDR_SPACE:  cfg_d.hdr_space   = cfg_data_i;
        irac_pkg::REG_BIT_MARK:   cfg_d.bit_mark    = cfg_data_i;
        irac_pkg::REG_ONE_SPACE:  cfg_d.one_space   = cfg_data_i;
        irac_pkg::REG_ZERO_SPACE: cfg_d.zero_space  = cfg_data_i;
        irac_pkg::REG_FOOTER:     cfg_d.footer      = cfg_data_i;
        irac_pkg::REG_GAP:        cfg_d.gap         = cfg_data_i;
        irac_pkg::REG_CSUM:       cfg_d.insert_csum = cfg_data_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_mark    <= irac_pkg::RST_HDR_MARK;
      cfg_q.hdr_space   <= irac_pkg::RST_HDR_SPACE;
      cfg_q.bit_mark    <= irac_pkg::RST_BIT_MARK;
      cfg_q.one_space   <= irac_pkg::RST_ONE_SPACE;
      cfg_q.zero_space  <= irac_pkg::RST_ZERO_SPACE;
      cfg_q.footer      <= irac_pkg::RST_FOOTER;
      cfg_q.gap         <= irac_pkg::RST_GAP;
      cfg_q.insert_csum <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irac_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_data_i     (s_axis_tdata_i),
    .in_start_i    (s_axis_tuser_i),
    .insert_csum_i (cfg_q.insert_csum),
    .push_o        (push),
    .push_desc_o   (push_desc),
    .push_ready_i  (push_ready)
  );

  irac_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_desc_o   (head_desc),
    .pop_valid_o  (head_valid)
  );

  irac_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_desc_i      (head_desc),
    .pop_o            (pop),
    .cfg_i            (cfg_q),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_mark_o       (m_axis_tdata_o[15:0]),
    .out_space_o      (m_axis_tdata_o[31:16]),
    .out_run_last_o   (m_axis_tlast_o),
    .out_frame_last_o (m_axis_tuser_o)
  );

  `IRAC_ASSERT_SAME(a_push_room, push, push_ready, "byte pushed into a full queue")
  `IRAC_ASSERT_SAME(a_pop_valid, pop, head_valid, "pop from an empty queue")
  `IRAC_ASSERT_SAME(a_gap_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o,
                    "frame gap pair not marked as last of its byte")
  `IRAC_ASSERT_NEXT(a_pop_out, pop, m_axis_tvalid_o && m_axis_tlast_o,
                    "finished byte did not leave a last pair")

endmodule
